[design/thm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package thm_pkg;

  // Action codes carried by an input item.
  localparam logic [2:0] ACT_REGISTER  = 3'd0;
  localparam logic [2:0] ACT_HEARTBEAT = 3'd1;
  localparam logic [2:0] ACT_CHECK     = 3'd2;
  localparam logic [2:0] ACT_ERROR     = 3'd3;
  localparam logic [2:0] ACT_WARNING   = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_LIM = 3'd5;

  // Reset values of the limit registers.
  localparam logic signed [7:0] TEMP_LO_RST  = -8'sd20;
  localparam logic signed [7:0] TEMP_HI_RST  = 8'sd60;
  localparam logic [15:0]       VOLT_LO_RST  = 16'd3300;
  localparam logic [15:0]       VOLT_HI_RST  = 16'd4200;
  localparam logic [6:0]        CPU_LIM_RST  = 7'd80;
  localparam logic [31:0]       STACK_LIM_RST = 32'd512;

  // Status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_WARN = 2'd1;
  localparam logic [1:0] STAT_CRIT = 2'd2;

  // Width of the alive mask and of the addressable slot range.
  localparam int unsigned MASK_W = 16;
  // Number of subsystems that the 3-bit field can address.
  localparam int unsigned SUB_ADDR_N = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         task_slot;
    logic [2:0]         subsystem;
    logic [31:0]        beat_timeout;
    logic [31:0]        now_ms;
    logic signed [7:0]  temp_reading;
    logic [15:0]        supply_level;
    logic [6:0]         cpu_load_pct;
    logic [31:0]        free_stack_bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]  overall_status;
    logic [15:0] alive_mask;
    logic [31:0] subsystem_errors;
    logic [31:0] total_errors;
    logic [31:0] total_warnings;
    logic        watchdog_kick;
  } result_t;

  // Write strobes from the controller to one slot cell.
  typedef struct packed {
    logic load;
    logic beat;
  } cell_wr_t;

  // Scan token and accumulated expiry flag passed from cell to cell.
  typedef struct packed {
    logic tok;
    logic crit;
  } scan_link_t;

endpackage

`default_nettype wire

[design/thm_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One task slot. It holds the slot's flags, timeout and last heartbeat time,
// and checks its own expiry when the scan token passes through.
module thm_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire thm_pkg::cell_wr_t    wr_i,
  input  wire logic [31:0]          timeout_i,
  input  wire logic [31:0]          now_i,
  input  wire thm_pkg::scan_link_t  link_i,
  output thm_pkg::scan_link_t       link_o,
  output logic                      alive_o
);

  logic        registered_q;
  logic        alive_q;
  logic [31:0] timeout_q;
  logic [31:0] last_q;
  logic [31:0] elapsed;
  logic        expire;
  logic        beat_ok;
  thm_pkg::scan_link_t link_q;

  // Modular elapsed time against this slot's timeout.
  assign elapsed = now_i - last_q;
  assign expire  = link_i.tok & registered_q & (elapsed > timeout_q);
  assign beat_ok = wr_i.beat & registered_q;

  // Flags of the slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      registered_q <= 1'b0;
      alive_q      <= 1'b0;
    end else if (wr_i.load) begin
      registered_q <= 1'b1;
      alive_q      <= 1'b1;
    end else if (beat_ok) begin
      alive_q <= 1'b1;
    end else if (expire) begin
      alive_q <= 1'b0;
    end
  end

  // Timeout and heartbeat time; they are read only once the slot is registered.
  always_ff @(posedge clk_i) begin
    if (wr_i.load) begin
      timeout_q <= timeout_i;
      last_q    <= now_i;
    end else if (beat_ok) begin
      last_q <= now_i;
    end
  end

  // Hand the token and the running expiry flag to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q.tok  <= link_i.tok;
      link_q.crit <= link_i.crit | expire;
    end
  end

  assign link_o  = link_q;
  assign alive_o = alive_q;

endmodule

`default_nettype wire

[design/task_heartbeat_health_monitor.sv]
// Task heartbeat health monitor. Items arrive on a valid/ready channel and
// each one gives exactly one result on the output channel; the block works on
// one item at a time. An item passes from the idle state through the apply
// state, a check item then through the scan state, where the scan token
// crosses a row of slot cells, one cell per cycle, and ends in the response
// state, which waits for a free output register. The next item is taken as
// soon as the previous result sits in the output register, even if unread.
// The configuration channel is always ready; the user must write the limit
// registers only while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module task_heartbeat_health_monitor #(
  parameter int unsigned TASK_SLOTS = 16,
  parameter int unsigned SUBSYSTEMS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire thm_pkg::item_t                    in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output thm_pkg::result_t                       out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [thm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [31:0]                       cfg_data_i
);

  // Only slots 0 to 15 can be addressed, so no cell exists beyond them.
  localparam int unsigned NCELL = (TASK_SLOTS < thm_pkg::MASK_W) ? TASK_SLOTS
                                                                  : thm_pkg::MASK_W;
  localparam int unsigned SUB_N = (SUBSYSTEMS < thm_pkg::SUB_ADDR_N) ? SUBSYSTEMS
                                                                     : thm_pkg::SUB_ADDR_N;
  localparam int unsigned SUB_W = (SUB_N > 1) ? $clog2(SUB_N) : 1;

  thm_pkg::state_e state_q, state_d;
  thm_pkg::item_t  item_q;
  thm_pkg::result_t out_q, result;
  logic            out_valid_q;

  logic signed [7:0] temp_lo_q, temp_hi_q;
  logic [15:0]       volt_lo_q, volt_hi_q;
  logic [6:0]        cpu_lim_q;
  logic [31:0]       stack_lim_q;

  logic [31:0] err_cnt_q [SUB_N];
  logic [31:0] err_tot_q;
  logic [31:0] warn_tot_q;
  logic [1:0]  status_q;

  logic in_take, apply_en, scan_start, resp_load, out_free, scan_done;
  logic sub_ok;
  logic [SUB_W-1:0] sub_idx;
  logic temp_bad, volt_bad, cpu_bad, stack_bad;
  logic [1:0] status_new;
  logic [thm_pkg::MASK_W-1:0] alive_mask;

  thm_pkg::cell_wr_t   cell_wr [NCELL];
  thm_pkg::scan_link_t links [NCELL+1];
  logic [NCELL-1:0]    cell_alive;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign in_take     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign scan_done   = links[NCELL].tok;

  // Controller next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      thm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = thm_pkg::ST_APPLY;
      end
      thm_pkg::ST_APPLY: begin
        state_d = (item_q.action == thm_pkg::ACT_CHECK) ? thm_pkg::ST_SCAN
                                                        : thm_pkg::ST_RESP;
      end
      thm_pkg::ST_SCAN: begin
        if (scan_done) state_d = thm_pkg::ST_RESP;
      end
      thm_pkg::ST_RESP: begin
        if (out_free) state_d = thm_pkg::ST_IDLE;
      end
      default: state_d = thm_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready_o = 1'b0;
    apply_en   = 1'b0;
    scan_start = 1'b0;
    resp_load  = 1'b0;
    unique case (state_q)
      thm_pkg::ST_IDLE:  in_ready_o = 1'b1;
      thm_pkg::ST_APPLY: begin
        apply_en   = 1'b1;
        scan_start = (item_q.action == thm_pkg::ACT_CHECK);
      end
      thm_pkg::ST_SCAN:  ;
      thm_pkg::ST_RESP:  resp_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_lo_q   <= thm_pkg::TEMP_LO_RST;
      temp_hi_q   <= thm_pkg::TEMP_HI_RST;
      volt_lo_q   <= thm_pkg::VOLT_LO_RST;
      volt_hi_q   <= thm_pkg::VOLT_HI_RST;
      cpu_lim_q   <= thm_pkg::CPU_LIM_RST;
      stack_lim_q <= thm_pkg::STACK_LIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        thm_pkg::CFG_TEMP_LO:   temp_lo_q   <= $signed(cfg_data_i[7:0]);
        thm_pkg::CFG_TEMP_HI:   temp_hi_q   <= $signed(cfg_data_i[7:0]);
        thm_pkg::CFG_VOLT_LO:   volt_lo_q   <= cfg_data_i[15:0];
        thm_pkg::CFG_VOLT_HI:   volt_hi_q   <= cfg_data_i[15:0];
        thm_pkg::CFG_CPU_LIM:   cpu_lim_q   <= cfg_data_i[6:0];
        thm_pkg::CFG_STACK_LIM: stack_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Row of slot cells; the token enters the first cell when a check starts.
  assign links[0].tok  = scan_start;
  assign links[0].crit = 1'b0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    assign cell_wr[i].load = apply_en & (item_q.action == thm_pkg::ACT_REGISTER)
                             & (32'(item_q.task_slot) == i);
    assign cell_wr[i].beat = apply_en & (item_q.action == thm_pkg::ACT_HEARTBEAT)
                             & (32'(item_q.task_slot) == i);

    thm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (cell_wr[i]),
      .timeout_i (item_q.beat_timeout),
      .now_i     (item_q.now_ms),
      .link_i    (links[i]),
      .link_o    (links[i+1]),
      .alive_o   (cell_alive[i])
    );
  end

  // Alive mask, with slots that have no cell reading as not alive.
  always_comb begin
    alive_mask = '0;
    for (int unsigned i = 0; i < NCELL; i++) begin
      alive_mask[i] = cell_alive[i];
    end
  end

  // Sensor rules, applied when the scan token leaves the last cell.
  assign temp_bad  = (item_q.temp_reading < temp_lo_q) ||
                     (item_q.temp_reading > temp_hi_q);
  assign volt_bad  = (item_q.supply_level < volt_lo_q) ||
                     (item_q.supply_level > volt_hi_q);
  assign cpu_bad   = item_q.cpu_load_pct > cpu_lim_q;
  assign stack_bad = item_q.free_stack_bytes < stack_lim_q;

  always_comb begin
    priority if (links[NCELL].crit || volt_bad) begin
      status_new = thm_pkg::STAT_CRIT;
    end else if (temp_bad || cpu_bad || stack_bad) begin
      status_new = thm_pkg::STAT_WARN;
    end else begin
      status_new = thm_pkg::STAT_OK;
    end
  end

  // Subsystem addressing.
  assign sub_ok  = 32'(item_q.subsystem) < SUB_N;
  assign sub_idx = item_q.subsystem[SUB_W-1:0];

  // Counters and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SUB_N; i++) begin
        err_cnt_q[i] <= '0;
      end
      err_tot_q  <= '0;
      warn_tot_q <= '0;
      status_q   <= thm_pkg::STAT_OK;
    end else begin
      if (apply_en && sub_ok && item_q.action == thm_pkg::ACT_ERROR) begin
        err_cnt_q[sub_idx] <= err_cnt_q[sub_idx] + 32'd1;
        err_tot_q          <= err_tot_q + 32'd1;
      end
      if (apply_en && sub_ok && item_q.action == thm_pkg::ACT_WARNING) begin
        warn_tot_q <= warn_tot_q + 32'd1;
      end
      if (state_q == thm_pkg::ST_SCAN && scan_done) begin
        status_q <= status_new;
      end
    end
  end

  // Result of the item, formed once all of its updates are done.
  always_comb begin
    result.overall_status   = status_q;
    result.alive_mask       = alive_mask;
    result.subsystem_errors = sub_ok ? err_cnt_q[sub_idx] : 32'd0;
    result.total_errors     = err_tot_q;
    result.total_warnings   = warn_tot_q;
    result.watchdog_kick    = (item_q.action == thm_pkg::ACT_CHECK);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[design/thm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the health monitor.
module thm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire thm_pkg::result_t              out_data_o
);

  // A result waiting on the output holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // The block takes one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  // The status is always one of ok, warning or critical.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.overall_status <= thm_pkg::STAT_CRIT)
    else $error("unknown status code");

  // A new result is only loaded while the block cannot take an item.
  a_no_ready_at_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without an item in flight");

endmodule

bind task_heartbeat_health_monitor thm_checker u_thm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
